@@ sv/planar_odometry_integrator_core_defines.svh @@
// Assertion macros shared by the odometry integrator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define POI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define POI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/poi_pkg.sv @@
// Package for the planar odometry integrator: widths, constants, state type, angle table.
// Depends on nothing.
package poi_pkg;

   localparam int POI_CORDIC_STEPS = 20;
   localparam int NUM_W = 56;
   localparam int DEN_W = 26;
   localparam int MC_W = 40;
   localparam int MP_W = 30;
   localparam int ACC_W = 72;
   localparam int VEC_W = 36;
   localparam int ANG_W = 34;

   localparam logic [DEN_W-1:0] DIV_MICRO = 26'd1000000;
   localparam logic [DEN_W-1:0] DIV_POS = 26'd65536000;
   localparam logic [DEN_W-1:0] DIV_TURN = 26'd6283185;
   localparam logic signed [NUM_W-1:0] ROUND_MICRO = 56'sd500000;
   localparam logic signed [NUM_W-1:0] ROUND_POS = 56'sd32768000;
   localparam logic signed [NUM_W-1:0] HALF_TURN = 56'sd3141593;
   localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [MP_W-1:0] GAIN_Q30 = 30'd652032874;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_ANG, S_CORDIC, S_MUL_GX, S_MUL_GY, S_MUL_PX, S_DIV_PX,
      S_MUL_PY, S_DIV_PY, S_MUL_YAW, S_DIV_HD, S_DIV_WRAP, S_OUT
   } state_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0: v = 30'd843314856;
         5'd1: v = 30'd497837829;
         5'd2: v = 30'd263043836;
         5'd3: v = 30'd133525158;
         5'd4: v = 30'd67021686;
         5'd5: v = 30'd33543515;
         5'd6: v = 30'd16775850;
         5'd7: v = 30'd8388437;
         5'd8: v = 30'd4194282;
         5'd9: v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd7;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/poi_div.sv @@
// Bit-serial restoring divider: signed numerator, positive divisor, floor quotient and remainder.
// Depends on poi_pkg.
module poi_div
   import poi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output logic signed [NUM_W-1:0] quo,
   output logic [DEN_W-1:0]        rem
);

   localparam int CNT_W = $clog2(NUM_W);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   neg_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [DEN_W-1:0]       rem_ff;
   logic [NUM_W-1:0]       quo_ff;
   logic [DEN_W:0]         trial;
   logic [DEN_W:0]         diff;
   logic                   ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff = trial - {1'b0, den_ff};
   assign ge = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(NUM_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[NUM_W-1];
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= num[NUM_W-1] ? ~num : num;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo = neg_ff ? $signed(~quo_ff) : $signed(quo_ff);
   assign rem = neg_ff ? den_ff - DEN_W'(1) - rem_ff : rem_ff;

endmodule

@@ sv/poi_mul.sv @@
// Bit-serial shift-and-add multiplier: signed multiplicand times unsigned multiplier.
// Depends on poi_pkg.
module poi_mul
   import poi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [MC_W-1:0]  mcand,
   input  logic [MP_W-1:0]         mplier,
   output logic                    done,
   output logic signed [ACC_W-1:0] prod
);

   localparam int CNT_W = $clog2(MP_W);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [ACC_W-1:0] mc_ff;
   logic [MP_W-1:0]         mp_ff;
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(MP_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MP_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mc_ff <= ACC_W'(mcand);
         mp_ff <= mplier;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= mc_ff <<< 1;
         mp_ff <= mp_ff >> 1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ sv/planar_odometry_integrator_core.sv @@
// Top level of the planar odometry integrator: sequencer, CORDIC rotation and pose registers.
// Depends on poi_pkg, poi_div, poi_mul and the assertion macro header.
//
//   Channel   Direction  Handshake             Words
//   req_      in         req_tvalid/tready     body velocities, yaw rate, elapsed time
//   rsp_      out        rsp_tvalid/tready     position x, position y, heading
//   csr_      in         csr_valid/ready       enable bit
//
// An enabled word runs through the shared bit-serial divider (five divisions) and
// multiplier (five products) and the CORDIC steps; a new word is accepted only in the idle
// state, so its result is loaded into the result register before the next acceptance.
// A disabled word goes from acceptance to the output state and then into the result register.
// Reset is synchronous and clears the pose, the enable bit and all handshakes.
// A new word is taken while the previous result waits; the sequencer stalls only before
// it would overwrite a result that has not yet been taken.
`include "planar_odometry_integrator_core_defines.svh"
module planar_odometry_integrator_core
   import poi_pkg::*;
#(
   parameter int CORDIC_STEPS = POI_CORDIC_STEPS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vel_x_mm_s[15:0], vel_y_mm_s[31:16], yaw_rate_urad_s[58:32], elapsed_us[78:59], pad
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x_um[47:0], pos_y_um[95:48], heading_urad[118:96], pad
   output logic [119:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

   state_type               state_ff;
   state_type               state_in;
   logic                    enable_ff;
   logic signed [15:0]      vx_ff;
   logic signed [15:0]      vy_ff;
   logic signed [26:0]      yaw_ff;
   logic [19:0]             dt_ff;
   logic signed [47:0]      pos_x_ff;
   logic signed [47:0]      pos_y_ff;
   logic signed [22:0]      heading_ff;
   logic signed [VEC_W-1:0] cx_ff;
   logic signed [VEC_W-1:0] cy_ff;
   logic signed [ANG_W-1:0] ca_ff;
   logic [STEP_W-1:0]       step_ff;
   logic signed [VEC_W-1:0] xg_ff;
   logic signed [VEC_W-1:0] yg_ff;
   logic                    rsp_tvalid_ff;
   logic [119:0]            rsp_tdata_ff;

   logic                    req_accept;
   logic                    rsp_load;
   logic                    div_start;
   logic signed [NUM_W-1:0] div_num;
   logic [DEN_W-1:0]        div_den;
   logic                    div_done;
   logic signed [NUM_W-1:0] div_quo;
   logic [DEN_W-1:0]        div_rem;
   logic                    mul_start;
   logic signed [MC_W-1:0]  mul_mcand;
   logic [MP_W-1:0]         mul_mplier;
   logic                    mul_done;
   logic signed [ACC_W-1:0] mul_prod;

   logic signed [ANG_W-1:0] ang0;
   logic signed [VEC_W-1:0] vx0;
   logic signed [VEC_W-1:0] vy0;
   logic signed [VEC_W-1:0] xs;
   logic signed [VEC_W-1:0] ys;
   logic signed [ANG_W-1:0] atan_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

   poi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   poi_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_mcand),
      .mplier (mul_mplier),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = enable_ff ? S_DIV_ANG : S_OUT;
            end
         end
         S_DIV_ANG:  if (div_done) state_in = S_CORDIC;
         S_CORDIC:   if (step_ff == STEP_W'(CORDIC_STEPS)) state_in = S_MUL_GX;
         S_MUL_GX:   if (mul_done) state_in = S_MUL_GY;
         S_MUL_GY:   if (mul_done) state_in = S_MUL_PX;
         S_MUL_PX:   if (mul_done) state_in = S_DIV_PX;
         S_DIV_PX:   if (div_done) state_in = S_MUL_PY;
         S_MUL_PY:   if (mul_done) state_in = S_DIV_PY;
         S_DIV_PY:   if (div_done) state_in = S_MUL_YAW;
         S_MUL_YAW:  if (mul_done) state_in = S_DIV_HD;
         S_DIV_HD:   if (div_done) state_in = S_DIV_WRAP;
         S_DIV_WRAP: if (div_done) state_in = S_OUT;
         S_OUT:      if (rsp_load) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = DIV_MICRO;
      mul_start = 1'b0;
      mul_mcand = '0;
      mul_mplier = '0;
      unique case (state_ff)
         S_IDLE: begin
            div_start = req_accept && enable_ff;
            div_num = {{3{heading_ff[22]}}, heading_ff, 30'd0} + ROUND_MICRO;
         end
         S_CORDIC: begin
            mul_start = (step_ff == STEP_W'(CORDIC_STEPS));
            mul_mcand = MC_W'(cx_ff);
            mul_mplier = GAIN_Q30;
         end
         S_MUL_GX: begin
            mul_start = mul_done;
            mul_mcand = MC_W'(cy_ff);
            mul_mplier = GAIN_Q30;
         end
         S_MUL_GY: begin
            mul_start = mul_done;
            mul_mcand = MC_W'(xg_ff);
            mul_mplier = MP_W'(dt_ff);
         end
         S_MUL_PX, S_MUL_PY: begin
            div_start = mul_done;
            div_num = mul_prod[NUM_W-1:0] + ROUND_POS;
            div_den = DIV_POS;
         end
         S_DIV_PX: begin
            mul_start = div_done;
            mul_mcand = MC_W'(yg_ff);
            mul_mplier = MP_W'(dt_ff);
         end
         S_DIV_PY: begin
            mul_start = div_done;
            mul_mcand = MC_W'(yaw_ff);
            mul_mplier = MP_W'(dt_ff);
         end
         S_MUL_YAW: begin
            div_start = mul_done;
            div_num = mul_prod[NUM_W-1:0] + ROUND_MICRO;
         end
         S_DIV_HD: begin
            div_start = div_done;
            div_num = NUM_W'(heading_ff) + div_quo + HALF_TURN;
            div_den = DIV_TURN;
         end
         default: begin
         end
      endcase
   end

   assign ang0 = div_quo[ANG_W-1:0];
   assign vx0 = {{(VEC_W-32){vx_ff[15]}}, vx_ff, 16'd0};
   assign vy0 = {{(VEC_W-32){vy_ff[15]}}, vy_ff, 16'd0};
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;
   assign atan_ext = ANG_W'(atan_q30(5'(step_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         enable_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         heading_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
         if (state_ff == S_DIV_PX && div_done) begin
            pos_x_ff <= pos_x_ff + div_quo[47:0];
         end
         if (state_ff == S_DIV_PY && div_done) begin
            pos_y_ff <= pos_y_ff + div_quo[47:0];
         end
         if (state_ff == S_DIV_WRAP && div_done) begin
            heading_ff <= 23'(div_rem) - 23'(HALF_TURN);
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         vx_ff <= req_tdata[15:0];
         vy_ff <= req_tdata[31:16];
         yaw_ff <= req_tdata[58:32];
         dt_ff <= req_tdata[78:59];
      end
      if (state_ff == S_DIV_ANG && div_done) begin
         step_ff <= '0;
         if (ang0 > HALF_PI_Q30) begin
            ca_ff <= ang0 - PI_Q30;
            cx_ff <= -vx0;
            cy_ff <= -vy0;
         end else if (ang0 < -HALF_PI_Q30) begin
            ca_ff <= ang0 + PI_Q30;
            cx_ff <= -vx0;
            cy_ff <= -vy0;
         end else begin
            ca_ff <= ang0;
            cx_ff <= vx0;
            cy_ff <= vy0;
         end
      end else if (state_ff == S_CORDIC && step_ff != STEP_W'(CORDIC_STEPS)) begin
         step_ff <= step_ff + STEP_W'(1);
         if (!ca_ff[ANG_W-1]) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            ca_ff <= ca_ff - atan_ext;
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            ca_ff <= ca_ff + atan_ext;
         end
      end
      if (state_ff == S_MUL_GX && mul_done) begin
         xg_ff <= mul_prod[VEC_W+29:30];
      end
      if (state_ff == S_MUL_GY && mul_done) begin
         yg_ff <= mul_prod[VEC_W+29:30];
      end
      if (rsp_load) begin
         rsp_tdata_ff <= {1'b0, heading_ff, pos_y_ff, pos_x_ff};
      end
   end

   `POI_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != S_IDLE,
      "word accepted but sequencer stayed idle")
   `POI_ASSERT_NEXT(a_out_loads, clock, reset, state_ff == S_OUT && !rsp_tvalid_ff,
      rsp_tvalid_ff, "result not presented from output state")
   `POI_ASSERT_NOW(a_heading_range, clock, reset, 1'b1,
      heading_ff >= -23'sd3141593 && heading_ff <= 23'sd3141591, "heading out of range")
   `POI_ASSERT_NOW(a_units_exclusive, clock, reset, div_done, !mul_done,
      "divider and multiplier finished together")

endmodule
